### hdl/lse_pkg.sv
// Shared types and constants for the LSB stego embedder.
// No dependencies; used by every module under hdl/.
package lse_pkg;

  localparam int LEN_BITS    = 16;  // bits of the length field
  localparam int DEN_BITS    = 8;   // bits of the density field
  localparam int MSG_IDX_W   = 16;  // widest message store index
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_COVER = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_DENSITY = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DONE    = 3'd4
  } phase_e;

  localparam logic REG_DENSITY = 1'b0;
  localparam logic REG_MSG_LEN = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] msg_index;
    logic [7:0]  msg_byte;
    logic [7:0]  cover_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] stego_byte;
    phase_e     phase;
  } out_word_t;

  // queue entry: a store write or a classified cover byte
  typedef struct packed {
    logic                 is_load;
    phase_e               phase;
    logic [7:0]           data;   // store data, cover byte or finished byte
    logic [MSG_IDX_W-1:0] addr0;
    logic [MSG_IDX_W-1:0] addr1;
    logic [2:0]           offset; // bit offset inside addr0 byte
    logic [3:0]           den;    // effective density
    logic [3:0]           nbits;  // message bits left in this chunk
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### hdl/lse_front.sv
// Front end: takes input words, tracks stream position, classifies cover bytes.
// Depends on lse_pkg.
module lse_front #(
  parameter int MSG_DEPTH    = 4096,
  parameter int HEADER_BYTES = 54
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  lse_pkg::in_word_t  in_data_i,
  input  logic [3:0]         density_i,
  input  logic [12:0]        msg_len_i,
  input  lse_pkg::q_status_t q_status_i,
  output logic               push_o,
  output lse_pkg::entry_t    entry_o
);

  localparam int BP_W  = $clog2(HEADER_BYTES + lse_pkg::LEN_BITS + lse_pkg::DEN_BITS + 1);
  localparam int PTR_W = $clog2(MSG_DEPTH * 8 + 1);

  logic [BP_W-1:0]  bp_q, bp_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;

  logic                          accept;
  logic [3:0]                    den;
  logic [lse_pkg::LEN_BITS-1:0]  len;
  logic [PTR_W-1:0]              total;
  logic [PTR_W-1:0]              remain;
  logic [3:0]                    nbits;
  logic [lse_pkg::MSG_IDX_W-1:0] addr0;
  logic [3:0]                    k_len;
  logic [2:0]                    k_den;
  logic [7:0]                    den8;

  assign accept = in_valid_i && !q_status_i.full;

  always_comb begin
    if (density_i == 4'd0) begin
      den = 4'd1;
    end else if (density_i > 4'd8) begin
      den = 4'd8;
    end else begin
      den = density_i;
    end
    if (32'(msg_len_i) > MSG_DEPTH) begin
      len = lse_pkg::LEN_BITS'(MSG_DEPTH);
    end else begin
      len = lse_pkg::LEN_BITS'(msg_len_i);
    end
  end

  assign den8   = 8'(den);
  assign total  = PTR_W'({len, 3'b000});
  assign remain = total - ptr_q;
  assign nbits  = (remain >= PTR_W'(den)) ? den : 4'(remain);
  assign addr0  = lse_pkg::MSG_IDX_W'(ptr_q >> 3);
  assign k_len  = 4'(32'(bp_q) - HEADER_BYTES);
  assign k_den  = 3'(32'(bp_q) - HEADER_BYTES - lse_pkg::LEN_BITS);

  always_comb begin
    bp_d            = bp_q;
    ptr_d           = ptr_q;
    push_o          = 1'b0;
    entry_o.is_load = 1'b0;
    entry_o.phase   = lse_pkg::PH_HEADER;
    entry_o.data    = in_data_i.cover_byte;
    entry_o.addr0   = addr0;
    entry_o.addr1   = (32'(addr0) + 1 >= MSG_DEPTH) ? addr0 : addr0 + 1'b1;
    entry_o.offset  = ptr_q[2:0];
    entry_o.den     = den;
    entry_o.nbits   = nbits;
    case (in_data_i.op)
      lse_pkg::OP_LOAD: begin
        entry_o.is_load = 1'b1;
        entry_o.data    = in_data_i.msg_byte;
        entry_o.addr0   = lse_pkg::MSG_IDX_W'(in_data_i.msg_index);
        push_o          = accept && (32'(in_data_i.msg_index) < MSG_DEPTH);
      end
      lse_pkg::OP_START: begin
        if (accept) begin
          bp_d  = '0;
          ptr_d = '0;
        end
      end
      lse_pkg::OP_COVER: begin
        push_o = accept;
        if (32'(bp_q) < HEADER_BYTES) begin
          entry_o.phase = lse_pkg::PH_HEADER;
          if (accept) bp_d = BP_W'(bp_q + 1'b1);
        end else if (32'(bp_q) < HEADER_BYTES + lse_pkg::LEN_BITS) begin
          entry_o.phase = lse_pkg::PH_LENGTH;
          entry_o.data  = {in_data_i.cover_byte[7:1], len[4'(15) - k_len]};
          if (accept) bp_d = BP_W'(bp_q + 1'b1);
        end else if (32'(bp_q) < HEADER_BYTES + lse_pkg::LEN_BITS + lse_pkg::DEN_BITS) begin
          entry_o.phase = lse_pkg::PH_DENSITY;
          entry_o.data  = {in_data_i.cover_byte[7:1], den8[3'(7) - k_den]};
          if (accept) bp_d = BP_W'(bp_q + 1'b1);
        end else if (ptr_q < total) begin
          entry_o.phase = lse_pkg::PH_PAYLOAD;
          if (accept) ptr_d = ptr_q + PTR_W'(nbits);
        end else begin
          entry_o.phase = lse_pkg::PH_DONE;
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q  <= '0;
      ptr_q <= '0;
    end else begin
      bp_q  <= bp_d;
      ptr_q <= ptr_d;
    end
  end

endmodule

### hdl/lse_queue.sv
// Four-entry queue between the front end and the back end.
// Depends on lse_pkg.
module lse_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lse_pkg::entry_t    entry_i,
  input  logic               pop_i,
  output lse_pkg::entry_t    entry_o,
  output lse_pkg::q_status_t status_o
);

  lse_pkg::entry_t                slot_q [lse_pkg::QUEUE_DEPTH];
  logic [lse_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [lse_pkg::QCNT_W-1:0]     count_q, count_d;

  assign status_o.full  = (count_q == lse_pkg::QCNT_W'(lse_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign entry_o        = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= entry_i;
  end

endmodule

### hdl/lse_back.sv
// Back end: message store, read stage, bit insertion and output register.
// Depends on lse_pkg.
module lse_back #(
  parameter int MSG_DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lse_pkg::entry_t    entry_i,
  input  lse_pkg::q_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lse_pkg::out_word_t out_data_o
);

  localparam int AW = $clog2(MSG_DEPTH);

  logic [7:0] mem [MSG_DEPTH];

  logic               s1_valid_q, s1_valid_d;
  lse_pkg::entry_t    s1_q;
  logic [7:0]         rd0_q, rd1_q;
  logic               s1_move;
  logic               out_valid_q;
  lse_pkg::out_word_t out_q;

  logic [15:0] window;
  logic [7:0]  chunk;
  logic [7:0]  mask;
  logic [7:0]  result;

  assign s1_move = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign pop_o   = !q_status_i.empty && (!s1_valid_q || s1_move);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop_o && !entry_i.is_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  // store write, registered two-port read
  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.is_load) begin
      mem[AW'(entry_i.addr0)] <= entry_i.data;
    end
    if (pop_o && !entry_i.is_load) begin
      rd0_q <= mem[AW'(entry_i.addr0)];
      rd1_q <= mem[AW'(entry_i.addr1)];
      s1_q  <= entry_i;
    end
  end

  // take the chunk at the bit offset, keep only live message bits, left aligned in den
  always_comb begin
    window = {rd0_q, rd1_q} << s1_q.offset;
    chunk  = (window[15:8] >> (4'd8 - s1_q.nbits)) << (s1_q.den - s1_q.nbits);
    mask   = 8'hFF >> (4'd8 - s1_q.den);
    if (s1_q.phase == lse_pkg::PH_PAYLOAD) begin
      result = (s1_q.data & ~mask) | chunk;
    end else begin
      result = s1_q.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.stego_byte <= result;
      out_q.phase      <= s1_q.phase;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/lsb_stego_embedder.sv
// Top level of the LSB stego embedder: config registers, front, queue, back.
// Depends on lse_pkg, lse_front, lse_queue, lse_back.
//
// Usage:
//   Input words carry an op: load writes msg_byte to the message store at
//   msg_index, start rewinds the stream position, cover passes one image byte.
//   Loads and starts make no output word; each cover word makes exactly one
//   output word (stego_byte, phase), in input order.
//   Load the message, then send start, then the cover bytes.
// Path: an accepted cover word is written into the queue, popped into the read
//   stage, and then registered in the output register that drives out_valid_o.
// Throughput: one word per cycle; the front end takes a word every cycle while
//   the four-entry queue has room, and the back end's two-read store port
//   serves every chunk in one access even when it spans two message bytes.
// Stall: out_stall_i holds the output register; the read stage and then the
//   queue fill behind it, and in_stall_o rises only when the queue is full.
// Reset: positions clear, density reads 1, message length 0. The message store
//   is not cleared; bytes must be loaded before they are embedded.
// Config: APB, density at 0x0, message_length at 0x4; write only when idle.
module lsb_stego_embedder #(
  parameter int MSG_DEPTH    = 4096,
  parameter int HEADER_BYTES = 54
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lse_pkg::in_word_t  in_data_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lse_pkg::out_word_t out_data_o,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [3:0]  density_q;
  logic [12:0] msg_len_q;
  logic        cfg_wr;

  lse_pkg::q_status_t q_stat;
  lse_pkg::entry_t    push_entry, head_entry;
  logic               push, pop;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      density_q <= 4'd1;
      msg_len_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        lse_pkg::REG_DENSITY: density_q <= pwdata[3:0];
        lse_pkg::REG_MSG_LEN: msg_len_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lse_pkg::REG_DENSITY: prdata = 32'(density_q);
      lse_pkg::REG_MSG_LEN: prdata = 32'(msg_len_q);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  // front stalls only on a full queue, never on anything downstream
  assign in_stall_o = q_stat.full;

  lse_front #(
    .MSG_DEPTH    (MSG_DEPTH),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .density_i  (density_q),
    .msg_len_i  (msg_len_q),
    .q_status_i (q_stat),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  lse_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_stat)
  );

  // back end owns the message store so loads and reads stay in stream order
  lse_back #(
    .MSG_DEPTH (MSG_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .q_status_i  (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------- checks
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_pop_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q_stat.full) |=> !q_stat.full)
    else $error("queue still full after pop");

endmodule
